// ===== rtl/triclinic_minimum_image_macros.svh =====
// ----------------------------------------------------------------------------
// triclinic minimum image assertion macros
// shared concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef TRICLINIC_MINIMUM_IMAGE_MACROS_SVH
`define TRICLINIC_MINIMUM_IMAGE_MACROS_SVH
`ifndef SYNTHESIS
`define TMI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TMI_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TMI_ASSERT(label, clk, rst_n, prop)
`define TMI_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/tmi_pkg.sv =====
// ----------------------------------------------------------------------------
// tmi package
// widths, register indexes and vector helpers for the minimum image block
// ----------------------------------------------------------------------------
`default_nettype none
package tmi_pkg;
  localparam int unsigned CompW  = 21;
  localparam int unsigned PosW   = 24;
  localparam int unsigned RegW   = 63;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DrW    = 32;  // internal separation width, values stay below 2^31
  localparam int unsigned DotW   = 56;
  localparam int unsigned FracDot = 30;
  localparam int unsigned NW     = 10;  // saturated period count
  localparam int unsigned SqW    = 64;
  localparam int unsigned NumCand = 8;

  typedef enum logic [IdxW-1:0] {
    REG_BOX_A   = 3'd0,
    REG_BOX_B   = 3'd1,
    REG_BOX_C   = 3'd2,
    REG_RECIP_U = 3'd3,
    REG_RECIP_V = 3'd4,
    REG_RECIP_W = 3'd5
  } reg_idx_e;

  typedef logic signed [DrW-1:0] vec_t [3];
  typedef logic signed [CompW-1:0] cvec_t [3];

  function automatic logic signed [CompW-1:0] comp(input logic [RegW-1:0] r, input int t);
    comp = r[t*CompW +: CompW];
  endfunction

  function automatic logic signed [NW-1:0] sat_floor(input logic signed [DotW-1:0] dot);
    logic signed [DotW-FracDot-1:0] f;
    f = dot[DotW-1:FracDot];  // arithmetic floor by dropping fraction
    if (f < -(DotW-FracDot)'(512)) sat_floor = -10'sd512;
    else if (f > (DotW-FracDot)'(511)) sat_floor = 10'sd511;
    else sat_floor = f[NW-1:0];
  endfunction

  function automatic logic signed [PosW-1:0] sat_out(input logic signed [DrW-1:0] v);
    if (v > DrW'(32'sd8388607)) sat_out = 24'sh7fffff;
    else if (v < -DrW'(32'sd8388608)) sat_out = 24'sh800000;
    else sat_out = v[PosW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/tmi_fold.sv =====
// ----------------------------------------------------------------------------
// tmi fold
// two-stage fold: dot product with a reciprocal vector, then subtract n*box
// ----------------------------------------------------------------------------
`default_nettype none
module tmi_fold (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [tmi_pkg::RegW-1:0]     recip_i,
  input  wire logic [tmi_pkg::RegW-1:0]     box_i,
  input  wire logic signed [tmi_pkg::DrW-1:0] dr_i [3],
  output logic                              valid_o,
  output logic signed [tmi_pkg::DrW-1:0]    dr_o [3]
);
  import tmi_pkg::*;
  logic signed [DotW-1:0] dot;
  logic signed [NW-1:0] n_d, n_q;
  logic signed [DrW-1:0] dr_q [3];
  logic signed [DrW-1:0] dr2_q [3];
  logic valid1_q, valid2_q;

  // products of 32x21 bits, summed exactly
  always_comb begin
    dot = '0;
    for (int t = 0; t < 3; t++) begin
      dot = dot + DotW'(dr_i[t]) * DotW'(comp(recip_i, t));
    end
    n_d = sat_floor(dot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      for (int t = 0; t < 3; t++) begin
        dr_q[t]  <= dr_i[t];
        dr2_q[t] <= dr_q[t] - DrW'(n_q * DrW'(comp(box_i, t)));
      end
    end
  end

  assign valid_o = valid2_q;
  assign dr_o = dr2_q;
endmodule
`default_nettype wire

// ===== rtl/tmi_search.sv =====
// ----------------------------------------------------------------------------
// tmi search
// pipelined search over the eight corner shifts for the shortest image
// ----------------------------------------------------------------------------
`default_nettype none
`include "triclinic_minimum_image_macros.svh"
module tmi_search (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [tmi_pkg::RegW-1:0]     box_a_i,
  input  wire logic [tmi_pkg::RegW-1:0]     box_b_i,
  input  wire logic [tmi_pkg::RegW-1:0]     box_c_i,
  input  wire logic signed [tmi_pkg::DrW-1:0] dr_i [3],
  output logic                              valid_o,
  output logic signed [tmi_pkg::PosW-1:0]   sep_o [3]
);
  import tmi_pkg::*;
  // stage 1: candidates, stage 2: squared norms, stage 3: pick, stage 4: saturate
  logic signed [DrW-1:0] cand_q [NumCand+1][3];
  logic [SqW-1:0] sq_q [NumCand+1];
  logic signed [DrW-1:0] cand2_q [NumCand+1][3];
  logic signed [DrW-1:0] best_q [3];
  logic signed [PosW-1:0] sep_q [3];
  logic [3:0] v_q;
  logic signed [DrW-1:0] best_d [3];
  logic [SqW-1:0] dmin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[2:0], valid_i};
  end

  always_comb begin
    dmin = sq_q[0];
    best_d = cand2_q[0];
    for (int m = 1; m <= NumCand; m++) begin
      if (sq_q[m] < dmin) begin
        dmin = sq_q[m];
        best_d = cand2_q[m];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < 3; t++) begin
        cand_q[0][t] <= dr_i[t];
        for (int m = 0; m < NumCand; m++) begin
          cand_q[m+1][t] <= dr_i[t]
            - ((m & 4) != 0 ? DrW'(comp(box_a_i, t)) : '0)
            - ((m & 2) != 0 ? DrW'(comp(box_b_i, t)) : '0)
            - ((m & 1) != 0 ? DrW'(comp(box_c_i, t)) : '0);
        end
      end
      for (int m = 0; m <= NumCand; m++) begin
        sq_q[m] <= SqW'(cand_q[m][0] * cand_q[m][0]) + SqW'(cand_q[m][1] * cand_q[m][1])
                 + SqW'(cand_q[m][2] * cand_q[m][2]);
        cand2_q[m] <= cand_q[m];
      end
      best_q <= best_d;
      for (int t = 0; t < 3; t++) sep_q[t] <= sat_out(best_q[t]);
    end
  end

  assign valid_o = v_q[3];
  assign sep_o = sep_q;

  `TMI_ASSERT(a_valid_shift, clk_i, rst_ni, en_i |=> v_q[1] == $past(v_q[0]))
  `TMI_ASSERT(a_hold, clk_i, rst_ni, !en_i |=> $stable(v_q))
  `TMI_ASSERT_RST(a_rst, clk_i, !rst_ni |=> v_q == '0)
endmodule
`default_nettype wire

// ===== rtl/triclinic_minimum_image.sv =====
// ----------------------------------------------------------------------------
// triclinic minimum image
// shortest periodic image of a pair separation in a triclinic cell
// ----------------------------------------------------------------------------
// usage:
//  - s_axis carries one pair request per beat: first x,y,z then second x,y,z,
//    each 24-bit signed q11.12
//  - m_axis returns one separation request per pair: x,y,z, 24-bit signed
//  - cfg_we_i/cfg_idx_i/cfg_data_i load box vectors a,b,c (index 0..2) and
//    reciprocal vectors u,v,w (3..5); other indexes are ignored; write only
//    while no request is in flight
//  - three folds of two stages each, then four stages of candidate forming,
//    squared norms, selection and saturation; each fold stage holds three
//    multiplies; throughput is one pair per cycle unless m_axis stalls
//  - the whole pipeline advances when the output register is empty or taken;
//    a stall at m_axis freezes every stage, nothing is lost or repeated
//  - reset clears all valid bits and the six registers to zero
// ----------------------------------------------------------------------------
`default_nettype none
`include "triclinic_minimum_image_macros.svh"
module triclinic_minimum_image (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tmi_pkg::IdxW-1:0]   cfg_idx_i,
  input  wire logic [tmi_pkg::RegW-1:0]   cfg_data_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  wire logic [143:0]               s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // sep_x, sep_y, sep_z
  output logic [71:0]                     m_axis_tdata
);
  import tmi_pkg::*;

  logic [RegW-1:0] regs_q [NumRegs];
  logic en;
  logic signed [DrW-1:0] dr0 [3];
  logic signed [DrW-1:0] dr1 [3];
  logic signed [DrW-1:0] dr2 [3];
  logic signed [DrW-1:0] dr3 [3];
  logic v1, v2, v3, vo;
  logic signed [PosW-1:0] sep [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) regs_q[r] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_A:   regs_q[0] <= cfg_data_i;
        REG_BOX_B:   regs_q[1] <= cfg_data_i;
        REG_BOX_C:   regs_q[2] <= cfg_data_i;
        REG_RECIP_U: regs_q[3] <= cfg_data_i;
        REG_RECIP_V: regs_q[4] <= cfg_data_i;
        REG_RECIP_W: regs_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output slot is free or being drained
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // difference second minus first, sign extended
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      dr0[t] = DrW'($signed(s_axis_tdata[(3+t)*PosW +: PosW]))
             - DrW'($signed(s_axis_tdata[t*PosW +: PosW]));
    end
  end

  tmi_fold u_fold_a (.clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .recip_i(regs_q[3]), .box_i(regs_q[0]), .dr_i(dr0), .valid_o(v1), .dr_o(dr1));
  tmi_fold u_fold_b (.clk_i, .rst_ni, .en_i(en), .valid_i(v1),
    .recip_i(regs_q[4]), .box_i(regs_q[1]), .dr_i(dr1), .valid_o(v2), .dr_o(dr2));
  tmi_fold u_fold_c (.clk_i, .rst_ni, .en_i(en), .valid_i(v2),
    .recip_i(regs_q[5]), .box_i(regs_q[2]), .dr_i(dr2), .valid_o(v3), .dr_o(dr3));

  tmi_search u_search (.clk_i, .rst_ni, .en_i(en), .valid_i(v3),
    .box_a_i(regs_q[0]), .box_b_i(regs_q[1]), .box_c_i(regs_q[2]),
    .dr_i(dr3), .valid_o(vo), .sep_o(sep));

  assign m_axis_tvalid = vo;
  assign m_axis_tdata = {sep[2], sep[1], sep[0]};

  `TMI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `TMI_ASSERT(a_data_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `TMI_ASSERT(a_ready, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
endmodule
`default_nettype wire
